// File: sv/deadline_job_sequencer_macros.svh
// Assertion helpers shared by the sequencer modules.
`ifndef DEADLINE_JOB_SEQUENCER_MACROS_SVH
`define DEADLINE_JOB_SEQUENCER_MACROS_SVH

// Property that must hold every clock outside reset.
`define DJS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication checked on the next clock.
`define DJS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/djs_pkg.sv
// ----------------------------------------------------------------------------
// djs_pkg
// Types and constants shared by the deadline job sequencer.
// ----------------------------------------------------------------------------
package djs_pkg;
	localparam int unsigned ProfitW = 16;
	localparam int unsigned DeadlineW = 16;
	localparam int unsigned CountW = 9;
	localparam int unsigned TotalW = 24;
	localparam logic [CountW-1:0] CountMax = '1;
	localparam logic [TotalW-1:0] TotalMax = '1;

	// Status from the scheduler core (djs_core) to the top-level block.
	typedef struct packed {
		logic busy;
		logic done;
	} djs_stat_t;
endpackage

// File: sv/deadline_job_sequencer.sv
// ----------------------------------------------------------------------------
// deadline_job_sequencer
// Greedy job sequencing with deadlines over a loaded set of jobs.
// ----------------------------------------------------------------------------
// channel | signals                               | direction
// in      | in_valid in_stall profit deadline last_job | to block
// out     | out_valid out_stall job_count total_profit overflow | from block
//
// Jobs load at one word per cycle while in_stall is low. After the closing word the
// block stalls its input while it clears the slot map (all MAX_DEADLINE+1 slots)
// and runs one pass per stored job: a scan of all stored jobs, then a probe of
// each slot down from the deadline until a free one is found or the walk reaches
// slot zero, where the job is not placed.
// The result word holds until taken; meanwhile the next set loads, and only its
// closing word is stalled. arst_n clears all control state.
// ----------------------------------------------------------------------------
`include "deadline_job_sequencer_macros.svh"
module deadline_job_sequencer import djs_pkg::*; #(
	parameter int unsigned MAX_JOBS = 256,
	parameter int unsigned MAX_DEADLINE = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [ProfitW-1:0] profit,
	input  logic [DeadlineW-1:0] deadline,
	input  logic last_job,
	output logic out_valid,
	input  logic out_stall,
	output logic [CountW-1:0] job_count,
	output logic [TotalW-1:0] total_profit,
	output logic overflow
);
	localparam int unsigned NW = $clog2(MAX_JOBS+1);
	localparam int unsigned SW = $clog2(MAX_DEADLINE+1);

	logic [NW-1:0] loaded_q;
	logic dropped_q;
	logic run_q;
	logic out_vld_q;
	logic take;
	logic wr;
	logic start;
	logic [SW-1:0] dl_clamped;
	djs_stat_t stat;
	logic [CountW-1:0] cnt;
	logic [TotalW-1:0] tot;

	assign in_stall = run_q || (out_vld_q && last_job);
	assign take = in_valid && !in_stall;
	assign wr = take && (loaded_q != NW'(MAX_JOBS));
	assign start = take && last_job;
	assign dl_clamped = (deadline > DeadlineW'(MAX_DEADLINE)) ? SW'(MAX_DEADLINE)
		: deadline[SW-1:0];

	djs_core #(.MAX_JOBS(MAX_JOBS), .MAX_DEADLINE(MAX_DEADLINE)) u_core (
		.clk(clk), .arst_n(arst_n), .wr(wr), .wr_profit(profit),
		.wr_deadline(dl_clamped), .n_jobs(loaded_q), .start(start),
		.stat(stat), .count(cnt), .total(tot)
	);

	// Load counter, drop flag and result handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= '0;
			dropped_q <= 1'b0;
			run_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (wr) loaded_q <= loaded_q + 1'b1;
			if (take && !wr) dropped_q <= 1'b1;
			if (start) run_q <= 1'b1;
			if (stat.done) begin
				run_q <= 1'b0;
				out_vld_q <= 1'b1;
				loaded_q <= '0;
				dropped_q <= 1'b0;
			end
			if (out_vld_q && !out_stall) out_vld_q <= 1'b0;
		end
	end

	// Result word register
	always_ff @(posedge clk) begin
		if (stat.done) begin
			job_count <= cnt;
			total_profit <= tot;
			overflow <= dropped_q;
		end
	end

	assign out_valid = out_vld_q;

	`DJS_ASSERT(a_excl, !(run_q && out_vld_q), "run and result overlap")
	`DJS_ASSERT(a_load, loaded_q <= NW'(MAX_JOBS), "load count overran")
	`DJS_ASSERT_NEXT(a_run, start, run_q, "start did not launch")
	`DJS_ASSERT(a_busy, !(stat.busy && out_vld_q), "core busy with result pending")
endmodule

// File: sv/djs_core.sv
// ----------------------------------------------------------------------------
// djs_core
// Job store and greedy scheduler. Each pass scans all stored jobs for the
// next one in falling-profit order (earliest index on ties), then walks slots
// down from its deadline until a free one is found or slot zero is reached.
// ----------------------------------------------------------------------------
`include "deadline_job_sequencer_macros.svh"
module djs_core import djs_pkg::*; #(
	parameter int unsigned MAX_JOBS = 256,
	parameter int unsigned MAX_DEADLINE = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  logic [ProfitW-1:0] wr_profit,
	input  logic [$clog2(MAX_DEADLINE+1)-1:0] wr_deadline,
	input  logic [$clog2(MAX_JOBS+1)-1:0] n_jobs,
	input  logic start,
	output djs_stat_t stat,
	output logic [CountW-1:0] count,
	output logic [TotalW-1:0] total
);
	localparam int unsigned IW = $clog2(MAX_JOBS);
	localparam int unsigned NW = $clog2(MAX_JOBS+1);
	localparam int unsigned SW = $clog2(MAX_DEADLINE+1);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001, S_CLR = 7'b0000010, S_SCAN = 7'b0000100,
		S_WAIT = 7'b0001000, S_SLOT = 7'b0010000, S_CHK = 7'b0100000,
		S_DONE = 7'b1000000
	} st_t;

	st_t state_q;
	logic [ProfitW-1:0] prof_mem [MAX_JOBS];
	logic [SW-1:0] dl_mem [MAX_JOBS];
	logic slot_mem [MAX_DEADLINE+1];
	logic [IW-1:0] rd_addr;
	logic [ProfitW-1:0] rd_prof_q;
	logic [SW-1:0] rd_dl_q;
	logic [NW-1:0] scan_q;
	logic [NW-1:0] pass_q;
	logic rd_vld_q;
	logic [IW-1:0] rd_idx_q;
	logic best_vld_q;
	logic [IW-1:0] best_idx_q;
	logic [ProfitW-1:0] best_prof_q;
	logic [SW-1:0] best_dl_q;
	logic [ProfitW-1:0] prev_prof_q;
	logic [IW-1:0] prev_idx_q;
	logic elig;
	logic [SW-1:0] slot_q;
	logic slot_dat_q;
	logic [CountW-1:0] count_q;
	logic [TotalW-1:0] total_q;
	logic [TotalW:0] sum;

	assign rd_addr = scan_q[IW-1:0];
	assign sum = {1'b0, total_q} + {{(TotalW+1-ProfitW){1'b0}}, best_prof_q};

	// Job not yet placed: after the previous pick in (profit down, index up) order
	assign elig = (pass_q == '0) || (rd_prof_q < prev_prof_q) ||
		(rd_prof_q == prev_prof_q && rd_idx_q > prev_idx_q);

	// Job memories: write on load, registered read during scan.
	always_ff @(posedge clk) begin
		if (wr) begin
			prof_mem[n_jobs[IW-1:0]] <= wr_profit;
			dl_mem[n_jobs[IW-1:0]] <= wr_deadline;
		end
		rd_prof_q <= prof_mem[rd_addr];
		rd_dl_q <= dl_mem[rd_addr];
	end

	// Slot map memory: clear sweep, registered lookup, mark.
	always_ff @(posedge clk) begin
		if (state_q == S_CLR)
			slot_mem[slot_q] <= 1'b0;
		else if (state_q == S_CHK && !slot_dat_q)
			slot_mem[slot_q] <= 1'b1;
		slot_dat_q <= slot_mem[slot_q];
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			scan_q <= '0;
			pass_q <= '0;
			rd_vld_q <= 1'b0;
			best_vld_q <= 1'b0;
			slot_q <= '0;
			count_q <= '0;
			total_q <= '0;
			rd_idx_q <= '0;
			best_idx_q <= '0;
			best_prof_q <= '0;
			best_dl_q <= '0;
			prev_prof_q <= '0;
			prev_idx_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_CLR;
						slot_q <= SW'(MAX_DEADLINE);
						count_q <= '0;
						total_q <= '0;
						pass_q <= '0;
					end
				end
				S_CLR: begin
					if (slot_q == '0) begin
						state_q <= S_SCAN;
						scan_q <= '0;
						rd_vld_q <= 1'b0;
						best_vld_q <= 1'b0;
					end else
						slot_q <= slot_q - 1'b1;
				end
				S_SCAN: begin
					// Issue one read per cycle; compare the previous read.
					if (scan_q < n_jobs) begin
						rd_vld_q <= 1'b1;
						rd_idx_q <= scan_q[IW-1:0];
						scan_q <= scan_q + 1'b1;
					end else begin
						rd_vld_q <= 1'b0;
						state_q <= S_WAIT;
					end
					if (rd_vld_q && elig &&
						(!best_vld_q || rd_prof_q > best_prof_q)) begin
						best_vld_q <= 1'b1;
						best_idx_q <= rd_idx_q;
						best_prof_q <= rd_prof_q;
						best_dl_q <= rd_dl_q;
					end
				end
				S_WAIT: begin
					if (pass_q == n_jobs)
						state_q <= S_DONE;
					else begin
						prev_prof_q <= best_prof_q;
						prev_idx_q <= best_idx_q;
						pass_q <= pass_q + 1'b1;
						slot_q <= best_dl_q;
						state_q <= S_SLOT;
					end
				end
				S_SLOT: begin
					// Slot zero ends the walk; otherwise look the slot up
					if (slot_q == '0) begin
						state_q <= S_SCAN;
						scan_q <= '0;
						rd_vld_q <= 1'b0;
						best_vld_q <= 1'b0;
					end else
						state_q <= S_CHK;
				end
				S_CHK: begin
					if (!slot_dat_q) begin
						if (count_q != CountMax) count_q <= count_q + 1'b1;
						total_q <= sum[TotalW] ? TotalMax : sum[TotalW-1:0];
						state_q <= S_SCAN;
						scan_q <= '0;
						rd_vld_q <= 1'b0;
						best_vld_q <= 1'b0;
					end else begin
						slot_q <= slot_q - 1'b1;
						state_q <= S_SLOT;
					end
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign stat.busy = (state_q != S_IDLE);
	assign stat.done = (state_q == S_DONE);
	assign count = count_q;
	assign total = total_q;

	`DJS_ASSERT(a_onehot, $onehot(state_q), "state not one-hot")
	`DJS_ASSERT_NEXT(a_start, state_q == S_IDLE && start, state_q == S_CLR, "start missed")
	`DJS_ASSERT(a_pass, state_q == S_IDLE || pass_q <= n_jobs, "pass overran job count")
	`DJS_ASSERT_NEXT(a_done, state_q == S_DONE, state_q == S_IDLE, "done held")
endmodule
